// File: design/rhhs_pkg.sv
package rhhs_pkg;

  localparam int TableSizeDef = 64;
  localparam int KeyBytesDef  = 4;
  localparam int KeyW         = 32;
  localparam int CountW       = 7;
  localparam logic [CountW-1:0] ThresholdRst = 7'd58;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_CONTAINS = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_FIND,
    ST_PLACE,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic hash_step;
    logic find_init;
    logic find_step;
    logic place_init;
    logic place_step;
    logic clear_init;
    logic clear_step;
    logic remove_hit;
    logic refuse;
    logic finish;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic  hash_done;
    logic  find_done;
    logic  hit;
    logic  place_done;
    logic  clear_done;
    logic  is_full;
    mode_e mode;
  } stat_t;

  // one djb2 step on a byte
  function automatic logic [31:0] djb2_step(logic [31:0] h, logic [7:0] b);
    djb2_step = (h << 5) + h + {24'd0, b};
  endfunction

endpackage

// File: design/rhhs_ctrl.sv
module rhhs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  rhhs_pkg::stat_t stat_i,
  output rhhs_pkg::ctrl_t ctrl_o
);

  rhhs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhhs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rhhs_pkg::ST_IDLE: begin
        if (start_i) state_d = rhhs_pkg::ST_HASH;
      end
      rhhs_pkg::ST_HASH: begin
        if (stat_i.mode == rhhs_pkg::MODE_CLEAR) state_d = rhhs_pkg::ST_CLEAR;
        else if (stat_i.hash_done) state_d = rhhs_pkg::ST_FIND;
      end
      rhhs_pkg::ST_FIND: begin
        if (stat_i.hit) state_d = rhhs_pkg::ST_DONE;
        else if (stat_i.find_done) begin
          if (stat_i.mode == rhhs_pkg::MODE_INSERT && !stat_i.is_full)
            state_d = rhhs_pkg::ST_PLACE;
          else
            state_d = rhhs_pkg::ST_DONE;
        end
      end
      rhhs_pkg::ST_PLACE: begin
        if (stat_i.place_done) state_d = rhhs_pkg::ST_DONE;
      end
      rhhs_pkg::ST_CLEAR: begin
        if (stat_i.clear_done) state_d = rhhs_pkg::ST_DONE;
      end
      rhhs_pkg::ST_DONE: state_d = rhhs_pkg::ST_IDLE;
      default: state_d = rhhs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      rhhs_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        ctrl_o.load = start_i;
      end
      rhhs_pkg::ST_HASH: begin
        ctrl_o.hash_step  = 1'b1;
        ctrl_o.find_init  = stat_i.hash_done;
        ctrl_o.clear_init = (stat_i.mode == rhhs_pkg::MODE_CLEAR);
      end
      rhhs_pkg::ST_FIND: begin
        ctrl_o.find_step  = 1'b1;
        ctrl_o.remove_hit = stat_i.hit && (stat_i.mode == rhhs_pkg::MODE_REMOVE);
        ctrl_o.refuse     = !stat_i.hit && stat_i.find_done &&
                            (stat_i.mode == rhhs_pkg::MODE_INSERT) && stat_i.is_full;
        ctrl_o.place_init = !stat_i.hit && stat_i.find_done &&
                            (stat_i.mode == rhhs_pkg::MODE_INSERT) && !stat_i.is_full;
      end
      rhhs_pkg::ST_PLACE: ctrl_o.place_step = 1'b1;
      rhhs_pkg::ST_CLEAR: ctrl_o.clear_step = 1'b1;
      rhhs_pkg::ST_DONE:  ctrl_o.finish     = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: design/rhhs_dp.sv
module rhhs_dp #(
  parameter int TableSize = rhhs_pkg::TableSizeDef,
  parameter int KeyBytes  = rhhs_pkg::KeyBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  mode_i,
  input  logic [rhhs_pkg::KeyW-1:0]   key_i,
  input  logic                        last_in_batch_i,
  input  logic                        cfg_we_i,
  input  logic [rhhs_pkg::CountW-1:0] cfg_data_i,
  input  rhhs_pkg::ctrl_t             ctrl_i,
  output rhhs_pkg::stat_t             stat_o,
  output logic                        done_o,
  output logic                        found_o,
  output logic                        status_o,
  output logic [rhhs_pkg::CountW-1:0] count_o,
  output logic                        last_in_batch_out_o
);

  localparam int IdxW  = $clog2(TableSize);
  localparam int CntW  = $clog2(TableSize + 1);
  localparam int ByteW = (KeyBytes > 1) ? $clog2(KeyBytes) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSize - 1);
  localparam int Pow2  = ((TableSize & (TableSize - 1)) == 0) ? 1 : 0;
  // hash / TableSize = (hash * Recip) >> RecSh, exact for any 32-bit hash
  localparam int RecSh = 32 + IdxW;
  localparam logic [64:0] Recip =
    65'(((65'd1 << RecSh) + 65'(TableSize) - 65'd1) / 65'(TableSize));

  // slot storage: key and distance in memory, valid bits in flops
  logic [rhhs_pkg::KeyW-1:0] key_mem [TableSize];
  logic [IdxW-1:0]           dist_mem [TableSize];
  logic [TableSize-1:0]      valid_q;

  logic [rhhs_pkg::CountW-1:0] thr_q;
  logic [CntW-1:0]             cnt_q;
  rhhs_pkg::mode_e             mode_q;
  logic [rhhs_pkg::KeyW-1:0]   key_q;
  logic                        last_q;
  logic [31:0]                 hash_q;
  logic [ByteW:0]              byte_q;
  logic                        hmod_q;   // product registered
  logic                        hrdy_q;   // remainder registered
  logic [64:0]                 hprod_q;
  logic [31:0]                 hquo;
  logic [IdxW-1:0]             pos_q;
  logic [CntW-1:0]             n_q;
  logic                        rd_q;     // read data of pos_q is valid
  logic [rhhs_pkg::KeyW-1:0]   rkey_q;
  logic [IdxW-1:0]             rdist_q;
  logic [rhhs_pkg::KeyW-1:0]   ckey_q;
  logic [IdxW-1:0]             cdist_q;
  logic                        found_q, status_q, done_q;
  logic [31:0]                 hred_q;
  logic [IdxW-1:0]             hred_home_q;

  logic [rhhs_pkg::KeyW-1:0] knorm;
  logic [7:0]                kbyte;
  logic [IdxW-1:0]           pos_nx;
  logic                      slot_v;
  logic                      slot_hit;

  always_comb begin
    knorm = key_i;
    if (KeyBytes < 4) knorm = key_i & ((32'd1 << (8 * KeyBytes)) - 32'd1);
  end

  assign kbyte    = (byte_q < 4) ? key_q[8*byte_q[1:0] +: 8] : 8'd0;
  assign pos_nx   = (pos_q == LastIdx) ? '0 : pos_q + 1'b1;
  assign slot_v   = valid_q[pos_q];
  assign slot_hit = rd_q && slot_v && (rkey_q == key_q);
  assign hquo     = 32'(hprod_q >> RecSh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= rhhs_pkg::ThresholdRst;
      cnt_q   <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctrl_i.finish;
      if (cfg_we_i) thr_q <= cfg_data_i;
      if (ctrl_i.remove_hit) begin
        valid_q[pos_q] <= 1'b0;
        cnt_q <= cnt_q - 1'b1;
      end
      if (ctrl_i.place_step && rd_q && !slot_v) begin
        valid_q[pos_q] <= 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctrl_i.clear_step) begin
        valid_q[pos_q] <= 1'b0;
        cnt_q <= '0;
      end
    end
  end

  // operation registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mode_q   <= rhhs_pkg::mode_e'(mode_i);
      key_q    <= knorm;
      last_q   <= last_in_batch_i;
      hash_q   <= 32'd5381;
      byte_q   <= '0;
      hmod_q   <= 1'b0;
      hrdy_q   <= 1'b0;
      found_q  <= 1'b0;
      status_q <= 1'b0;
    end
    if (ctrl_i.hash_step) begin
      if (byte_q < (ByteW+1)'(KeyBytes)) begin
        hash_q <= rhhs_pkg::djb2_step(hash_q, kbyte);
        byte_q <= byte_q + 1'b1;
      end else if (!hmod_q) begin
        hprod_q <= Recip * {33'd0, hash_q};
        hred_q  <= hash_q;
        hmod_q  <= 1'b1;
      end else if (!hrdy_q) begin
        hred_q <= hash_q - hquo * 32'(TableSize);
        hrdy_q <= 1'b1;
      end
    end
    if (ctrl_i.remove_hit || (ctrl_i.find_step && rd_q && slot_v && rkey_q == key_q))
      found_q <= 1'b1;
    if (ctrl_i.refuse) status_q <= 1'b1;
  end

  // memory read/write and scan pointer
  logic hash_ready;
  logic [IdxW-1:0] home;
  assign home       = (Pow2 != 0) ? hash_q[IdxW-1:0] : hred_q[IdxW-1:0];
  assign hash_ready = hmod_q && ((Pow2 != 0) || hrdy_q);

  logic find_hit;
  assign find_hit = ctrl_i.find_step && slot_hit;

  always_ff @(posedge clk_i) begin
    rd_q <= 1'b0;
    if (ctrl_i.find_init) begin
      pos_q   <= home;
      n_q     <= '0;
      ckey_q  <= key_q;
      cdist_q <= '0;
    end
    if (ctrl_i.clear_init) pos_q <= '0;
    if (ctrl_i.find_step && !find_hit) begin
      if (ctrl_i.place_init) begin
        pos_q <= hred_home_q;
        n_q   <= '0;
      end else if (rd_q) begin
        pos_q <= pos_nx;
        n_q   <= n_q + 1'b1;
      end else begin
        rkey_q <= key_mem[pos_q];
        rd_q   <= 1'b1;
      end
    end
    if (ctrl_i.place_step) begin
      if (!rd_q) begin
        rkey_q  <= key_mem[pos_q];
        rdist_q <= dist_mem[pos_q];
        rd_q    <= 1'b1;
      end else if (!slot_v) begin
        key_mem[pos_q]  <= ckey_q;
        dist_mem[pos_q] <= cdist_q;
      end else begin
        if (rdist_q < cdist_q) begin
          key_mem[pos_q]  <= ckey_q;
          dist_mem[pos_q] <= cdist_q;
          ckey_q  <= rkey_q;
          cdist_q <= (rdist_q == LastIdx) ? '0 : rdist_q + 1'b1;
        end else begin
          cdist_q <= (cdist_q == LastIdx) ? '0 : cdist_q + 1'b1;
        end
        pos_q <= pos_nx;
      end
    end
    if (ctrl_i.clear_step) pos_q <= pos_nx;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.find_init) hred_home_q <= home;
  end

  logic [rhhs_pkg::CountW-1:0] cnt_out;
  assign cnt_out = rhhs_pkg::CountW'(cnt_q);

  always_comb begin
    stat_o            = '0;
    stat_o.mode       = mode_q;
    stat_o.hash_done  = hash_ready;
    stat_o.find_done  = rd_q && !slot_hit && (n_q == CntW'(TableSize - 1));
    stat_o.hit        = slot_hit;
    stat_o.place_done = rd_q && !slot_v;
    stat_o.clear_done = (pos_q == LastIdx);
    stat_o.is_full    = ({{(32-CntW){1'b0}}, cnt_q} >= {25'd0, thr_q}) ||
                        (cnt_q >= CntW'(TableSize));
  end

  assign done_o              = done_q;
  assign found_o             = found_q;
  assign status_o            = status_q;
  assign count_o             = cnt_out;
  assign last_in_batch_out_o = last_q;

endmodule

// File: design/robin_hood_hash_set.sv
// Channel  | Ports                                        | Handshake
// command  | mode_i key_i last_in_batch_i                 | start_i & !busy_o
// result   | found_o status_o count_o last_in_batch_out_o | done_o, one cycle
// config   | full_threshold_we_i full_threshold_i          | we, any time idle
//
// One operation at a time. Hash folds in the KeyBytes key bytes one at a time, then
// registers the modulo product (and the remainder when TableSize is not a power of
// two); the scan then reads and compares each slot in turn, up to TableSize slots,
// and an insert then places the key. Clear walks all valid bits. Reset empties
// the table. The result is shown one cycle on done_o; the receiver cannot stall.
module robin_hood_hash_set #(
  parameter int TableSize = rhhs_pkg::TableSizeDef,
  parameter int KeyBytes  = rhhs_pkg::KeyBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  mode_i,
  input  logic [rhhs_pkg::KeyW-1:0]   key_i,
  input  logic                        last_in_batch_i,
  input  logic                        full_threshold_we_i,
  input  logic [rhhs_pkg::CountW-1:0] full_threshold_i,
  output logic                        done_o,
  output logic                        found_o,
  output logic                        status_o,
  output logic [rhhs_pkg::CountW-1:0] count_o,
  output logic                        last_in_batch_out_o
);

  rhhs_pkg::ctrl_t ctrl;
  rhhs_pkg::stat_t stat;

  rhhs_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .stat_i(stat), .ctrl_o(ctrl)
  );

  rhhs_dp #(.TableSize(TableSize), .KeyBytes(KeyBytes)) u_dp (
    .clk_i, .rst_ni, .mode_i, .key_i, .last_in_batch_i,
    .cfg_we_i(full_threshold_we_i), .cfg_data_i(full_threshold_i),
    .ctrl_i(ctrl), .stat_o(stat), .done_o, .found_o, .status_o, .count_o,
    .last_in_batch_out_o
  );

endmodule

// File: design/rhhs_checker.sv
module rhhs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       status_o,
  input logic       found_o,
  input logic [6:0] count_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("not busy after start");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");

  a_refuse_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> !found_o) else $error("refused a present key");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> count_o <= 7'd64) else $error("count out of range");

endmodule

bind robin_hood_hash_set rhhs_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .status_o, .found_o, .count_o
);

// File: bench/robin_hood_hash_set_tb.sv
`timescale 1ns / 100ps

module robin_hood_hash_set_tb;

  localparam int Slots = 64;

  typedef struct packed {
    logic                        found;
    logic                        status;
    logic [rhhs_pkg::CountW-1:0] count;
    logic                        last;
  } res_t;

  typedef struct {
    rhhs_pkg::mode_e mode;
    logic [31:0]     key;
    logic            last;
    logic            chk;
    res_t            want;
  } row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic [1:0]                  mode_i = rhhs_pkg::MODE_INSERT;
  logic [rhhs_pkg::KeyW-1:0]   key_i = '0;
  logic                        last_in_batch_i = 1'b0;
  logic                        full_threshold_we_i = 1'b0;
  logic [rhhs_pkg::CountW-1:0] full_threshold_i = '0;
  logic                        busy_o, done_o, found_o, status_o, last_in_batch_out_o;
  logic [rhhs_pkg::CountW-1:0] count_o;

  robin_hood_hash_set u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow table
  logic [31:0] tbl_key [Slots];
  logic        tbl_vld [Slots];
  logic [5:0]  tbl_dist[Slots];
  logic [6:0]  n_keys;
  logic [6:0]  thresh;

  res_t pending[$];
  int   errors = 0;
  int   send_gap = 9;
  logic [31:0] pool[16];

  function automatic logic [5:0] home_of(logic [31:0] k);
    logic [31:0] h;
    h = 32'd5381;
    for (int i = 0; i < 4; i++) h = h * 33 + k[8*i +: 8];
    return h[5:0];
  endfunction

  function automatic res_t apply_op(rhhs_pkg::mode_e m, logic [31:0] k, logic lst);
    res_t r;
    logic hit;
    logic [5:0] hm, pos, hit_pos, p, cd, td;
    logic [31:0] ck, tk;
    r = '0;
    r.last = lst;
    if (m == rhhs_pkg::MODE_CLEAR) begin
      for (int i = 0; i < Slots; i++) tbl_vld[i] = 1'b0;
      n_keys = '0;
    end else begin
      hm = home_of(k);
      hit = 1'b0;
      hit_pos = '0;
      for (int n = 0; n < Slots; n++) begin
        pos = hm + 6'(n);
        if (!hit && tbl_vld[pos] && tbl_key[pos] == k) begin
          hit = 1'b1;
          hit_pos = pos;
        end
      end
      r.found = hit;
      if (m == rhhs_pkg::MODE_INSERT && !hit) begin
        if (n_keys >= thresh || n_keys >= 7'(Slots)) r.status = 1'b1;
        else begin
          ck = k; cd = '0; p = hm;
          for (int n = 0; n < Slots; n++) begin
            if (!tbl_vld[p]) begin
              tbl_vld[p] = 1'b1; tbl_key[p] = ck; tbl_dist[p] = cd;
              n_keys = n_keys + 7'd1;
              break;
            end
            if (tbl_dist[p] < cd) begin
              tk = tbl_key[p]; td = tbl_dist[p];
              tbl_key[p] = ck; tbl_dist[p] = cd;
              ck = tk; cd = td;
            end
            p = p + 6'd1;
            cd = cd + 6'd1;
          end
        end
      end else if (m == rhhs_pkg::MODE_REMOVE && hit) begin
        tbl_vld[hit_pos] = 1'b0;
        if (n_keys != 7'd0) n_keys = n_keys - 7'd1;
      end
    end
    r.count = n_keys;
    return r;
  endfunction

  task automatic send(rhhs_pkg::mode_e m, logic [31:0] k, logic lst, logic chk,
                      res_t want);
    res_t p;
    while ($urandom_range(99) < send_gap) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1; mode_i <= m; key_i <= k; last_in_batch_i <= lst;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    p = apply_op(m, k, lst);
    pending.push_back(chk ? want : p);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_thresh(logic [6:0] v);
    full_threshold_we_i <= 1'b1; full_threshold_i <= v;
    @(negedge clk_i);
    full_threshold_we_i <= 1'b0;
    thresh = v;
  endtask

  always @(posedge clk_i) begin
    res_t got, w;
    if (rst_ni && done_o) begin
      got = '{found_o, status_o, count_o, last_in_batch_out_o};
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat exp none got %h", $time, got);
        errors++;
      end else begin
        w = pending.pop_front();
        if (got.found !== w.found) begin
          $display("%0t: found exp %b got %b", $time, w.found, got.found); errors++;
        end
        if (got.status !== w.status) begin
          $display("%0t: status exp %b got %b", $time, w.status, got.status); errors++;
        end
        if (got.count !== w.count) begin
          $display("%0t: count exp %0d got %0d", $time, w.count, got.count); errors++;
        end
        if (got.last !== w.last) begin
          $display("%0t: last exp %b got %b", $time, w.last, got.last); errors++;
        end
      end
    end
  end

  // directed rows: want typed only where obvious
  row_t dir[13] = '{
    '{rhhs_pkg::MODE_CONTAINS, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd0, 1'b0}},
    '{rhhs_pkg::MODE_REMOVE,   32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0, 1'b1}},
    '{rhhs_pkg::MODE_INSERT,   32'h0000_0000, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd1, 1'b0}},
    '{rhhs_pkg::MODE_INSERT,   32'h0000_0000, 1'b1, 1'b1, '{1'b1, 1'b0, 7'd1, 1'b1}},
    '{rhhs_pkg::MODE_INSERT,   32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd2, 1'b0}},
    '{rhhs_pkg::MODE_CONTAINS, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b1, 1'b0, 7'd2, 1'b0}},
    '{rhhs_pkg::MODE_INSERT,   32'h1234_5678, 1'b0, 1'b0, '0},
    '{rhhs_pkg::MODE_INSERT,   32'h8765_4321, 1'b1, 1'b0, '0},
    '{rhhs_pkg::MODE_REMOVE,   32'h0000_0000, 1'b0, 1'b0, '0},
    '{rhhs_pkg::MODE_CONTAINS, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rhhs_pkg::MODE_REMOVE,   32'h1234_5678, 1'b0, 1'b0, '0},
    '{rhhs_pkg::MODE_CLEAR,    32'hA5A5_A5A5, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0, 1'b1}},
    '{rhhs_pkg::MODE_CONTAINS, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd0, 1'b0}}
  };

  initial begin
    logic [31:0] k;
    int r, m;
    for (int i = 0; i < Slots; i++) begin
      tbl_vld[i] = 1'b0; tbl_key[i] = '0; tbl_dist[i] = '0;
    end
    n_keys = '0; thresh = rhhs_pkg::ThresholdRst;
    for (int i = 0; i < 16; i++) pool[i] = $urandom;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir[i]) send(dir[i].mode, dir[i].key, dir[i].last, dir[i].chk, dir[i].want);
    drain();
    // threshold one: second absent insert refused
    set_thresh(7'd1);
    send(rhhs_pkg::MODE_INSERT, 32'h0000_0001, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd1, 1'b0});
    send(rhhs_pkg::MODE_INSERT, 32'h0000_0002, 1'b0, 1'b1, '{1'b0, 1'b1, 7'd1, 1'b0});
    send(rhhs_pkg::MODE_INSERT, 32'h0000_0001, 1'b0, 1'b1, '{1'b1, 1'b0, 7'd1, 1'b0});
    drain();
    set_thresh(7'd0);
    send(rhhs_pkg::MODE_INSERT, 32'h0000_0003, 1'b1, 1'b1, '{1'b0, 1'b1, 7'd1, 1'b1});
    drain();
    set_thresh(7'd127);
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_thresh(7'd64);
        1: set_thresh(7'd58);
        2: set_thresh(7'd100);
        3: set_thresh(7'd8);
        4: set_thresh(7'd64);
        default: set_thresh(7'd33);
      endcase
      send_gap = (ph < 2) ? 9 : (ph < 4) ? 45 : 0;
      for (int i = 0; i < 200; i++) begin
        r = $urandom_range(99);
        k = (r < 70) ? (pool[4'($urandom_range(15))] ^
                        ($urandom_range(63) << $urandom_range(26)))
                     : $urandom;
        m = $urandom_range(99);
        if (m < 55)
          send(rhhs_pkg::MODE_INSERT, k, 1'($urandom_range(1)), 1'b0, '0);
        else if (m < 78)
          send(rhhs_pkg::MODE_REMOVE, k, 1'($urandom_range(1)), 1'b0, '0);
        else if (m < 98)
          send(rhhs_pkg::MODE_CONTAINS, k, 1'($urandom_range(1)), 1'b0, '0);
        else
          send(rhhs_pkg::MODE_CLEAR, k, 1'($urandom_range(1)), 1'b0, '0);
        if (i == 100) drain();
      end
    end
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
